// File: rtl/ufdx_pkg.sv
`timescale 1ns / 1ps

package ufdx_pkg;

    localparam logic [7:0] START_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_CTS     = 2'd2,
        KIND_LENERR  = 2'd3
    } kind_t;

    // one result beat
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] byte_index;
        logic       check_ok;
    } res_t;

endpackage

// File: rtl/ufdx_parser.sv
`timescale 1ns / 1ps

module ufdx_parser import ufdx_pkg::*; #(
    parameter int MTU_BYTES = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       max_length_we,
    input  logic [7:0] max_length_wdata,
    input  logic       byte_valid,
    input  logic [7:0] byte_in,
    output logic       res_valid,
    output res_t       res
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] max_length_reg;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0] running_xor_reg, running_xor_next;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_xor_next  = running_xor_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.data          = byte_in;
        res.byte_index    = 8'd0;
        res.check_ok      = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (byte_in == START_BYTE)
                begin
                    running_xor_next = START_BYTE;
                    phase_next       = PH_LEN;
                end
            end
            PH_LEN:
            begin
                frame_length_next = byte_in;
                bytes_seen_next   = 8'd0;
                if (byte_in == 8'd0)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.kind   = KIND_CTS;
                end
                else if (byte_in > max_length_reg)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.kind   = KIND_LENERR;
                end
                else
                begin
                    running_xor_next = running_xor_reg ^ byte_in;
                    phase_next       = PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_valid        = 1'b1;
                res.byte_index   = bytes_seen_reg;
                running_xor_next = running_xor_reg ^ byte_in;
                bytes_seen_next  = bytes_seen_reg + 8'd1;
                if (bytes_seen_next == frame_length_reg)
                    phase_next = PH_CHECK;
            end
            default:
            begin
                res_valid    = 1'b1;
                res.kind     = KIND_END;
                res.data     = frame_length_reg;
                res.check_ok = (byte_in == running_xor_reg);
                phase_next   = PH_HUNT;
            end
        endcase
        if (!byte_valid)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            max_length_reg   <= 8'(MTU_BYTES);
            frame_length_reg <= 8'd0;
            bytes_seen_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
        end
        else
        begin
            if (max_length_we)
                max_length_reg <= max_length_wdata;
            if (byte_valid)
            begin
                phase_reg        <= phase_next;
                frame_length_reg <= frame_length_next;
                bytes_seen_reg   <= bytes_seen_next;
                running_xor_reg  <= running_xor_next;
            end
        end
    end

endmodule

// File: rtl/ufdx_skid.sv
`timescale 1ns / 1ps

module ufdx_skid import ufdx_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  res_t up_res,
    output logic up_full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    logic out_valid_reg;
    res_t out_res_reg;
    logic skid_valid_reg;
    res_t skid_res_reg;
    logic out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign up_full   = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_res_reg <= skid_res_reg;
        end
        else if (up_valid)
        begin
            if (!out_valid_reg || out_take)
                out_res_reg <= up_res;
            else
                skid_res_reg <= up_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (up_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/uart_frame_deframer_xor_top.sv
`timescale 1ns / 1ps

// Length-prefixed frame deframer with XOR check byte.
// Input channel: one received byte per beat on rx_byte, in_valid / in_stall.
// Output channel: one result per beat on kind, data, byte_index, check_ok,
//   out_valid / out_stall. kind: payload byte, frame end, clear-to-send,
//   length error. Hunting bytes and the length byte of a good frame give
//   no result.
// max_length is written with max_length_we / max_length_wdata; the user must
//   write it only while idle, which the block itself does not enforce.
// Throughput: one byte per cycle while in_stall is low; the parser state
//   update is a single 8-bit XOR, compare and increment between registers.
// Stall: the output register plus a one-entry skid stage absorb a stalled
//   receiver; in_stall rises only once the skid stage holds a beat, so it
//   is a plain register output with no path from out_stall.
// Reset (rst_n low, async): parser back to hunting, running XOR, length and
//   count cleared, max_length back to MTU_BYTES, both output stages empty.
// No clearing pass; the block takes bytes from the first cycle after reset.

module uart_frame_deframer_xor_top import ufdx_pkg::*; #(
    parameter int MTU_BYTES = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       max_length_we,
    input  logic [7:0] max_length_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic [7:0] byte_index,
    output logic       check_ok
);

    logic in_take;
    logic res_valid;
    res_t res;
    res_t out_res;

    // a byte is taken whenever the skid stage is free
    assign in_take = in_valid && !in_stall;

    ufdx_parser #(
        .MTU_BYTES(MTU_BYTES)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata),
        .byte_valid       (in_take),
        .byte_in          (rx_byte),
        .res_valid        (res_valid),
        .res              (res)
    );

    ufdx_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (res_valid),
        .up_res    (res),
        .up_full   (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind       = out_res.kind;
    assign data       = out_res.data;
    assign byte_index = out_res.byte_index;
    assign check_ok   = out_res.check_ok;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Frame deframer bench.
// The driver offers received bytes from byte_q in bursts with random gaps.
// The receiver stalls at a rate that drifts from span to span, and once
// holds off for a long stretch. Every accepted byte goes through a local
// parser model, and the result beats it predicts queue up in
// pending_results. The monitor pops one entry per accepted result beat
// and compares it field by field.
module testbench;
    import ufdx_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    // Spare cycles at the end of settle cover bytes still inside the block
    // that produce nothing.
    localparam int DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'd0,
        ST_LEN   = 2'd1,
        ST_BODY  = 2'd2,
        ST_CHECK = 2'd3
    } parse_state_t;

    logic       clk              = 1'b0;
    logic       rst_n            = 1'b0;
    logic       max_length_we    = 1'b0;
    logic [7:0] max_length_wdata = 8'd0;
    logic       in_valid         = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte          = 8'd0;
    logic       out_valid;
    logic       out_stall        = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] byte_index;
    logic       check_ok;

    // Parser model: its own copy of the state and of max_length.
    parse_state_t rx_state    = ST_HUNT;
    logic [7:0]   rx_len      = 8'd0;
    logic [7:0]   rx_count    = 8'd0;
    logic [7:0]   rx_xor      = 8'd0;
    logic [7:0]   max_len_cfg = 8'd100;

    logic [7:0] byte_q[$];
    res_t       pending_results[$];
    res_t       want;

    int bytes_pushed = 0;
    int bytes_taken  = 0;
    int phase_beats  = 0;
    int results_seen = 0;
    int errors       = 0;

    // Sender and receiver pacing.
    int  burst_left = 0;
    int  gap_left   = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  stall_span = 0;
    int  stall_pct  = 0;

    uart_frame_deframer_xor_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .data             (data),
        .byte_index       (byte_index),
        .check_ok         (check_ok)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Steps the parser model by one accepted byte and queues the result
    // beat it gives, if any.
    task automatic track_frame_byte(input logic [7:0] b);
        res_t r;
        r = '0;
        case (rx_state)
            ST_HUNT:
            begin
                // anything but the start byte is dropped while hunting
                if (b == START_BYTE)
                begin
                    rx_xor   = START_BYTE;
                    rx_state = ST_LEN;
                end
            end
            ST_LEN:
            begin
                // 0xFF here is a length of 255, never a fresh start
                rx_len   = b;
                rx_count = 8'd0;
                if (b == 8'd0)
                begin
                    r.kind = KIND_CTS;
                    pending_results.push_back(r);
                    rx_state = ST_HUNT;
                end
                else if (b > max_len_cfg)
                begin
                    r.kind = KIND_LENERR;
                    r.data = b;
                    pending_results.push_back(r);
                    rx_state = ST_HUNT;
                end
                else
                begin
                    rx_xor   = rx_xor ^ b;
                    rx_state = ST_BODY;
                end
            end
            ST_BODY:
            begin
                r.kind       = KIND_PAYLOAD;
                r.data       = b;
                r.byte_index = rx_count;
                pending_results.push_back(r);
                rx_xor   = rx_xor ^ b;
                rx_count = rx_count + 8'd1;
                if (rx_count == rx_len)
                    rx_state = ST_CHECK;
            end
            default:
            begin
                // a bad check byte still closes the frame
                r.kind     = KIND_END;
                r.data     = rx_len;
                r.check_ok = (b == rx_xor);
                pending_results.push_back(r);
                rx_state = ST_HUNT;
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input bit counted);
        byte_q.push_back(b);
        bytes_pushed++;
        if (counted)
            phase_beats++;
    endtask

    // Start byte and length, then the payload and check byte when the
    // length is one the block takes. ramp fills the payload with its index.
    task automatic push_frame(input int len, input bit good, input bit ramp);
        logic [7:0] sum;
        logic [7:0] b;
        sum = START_BYTE ^ len[7:0];
        push_byte(START_BYTE, 1'b1);
        push_byte(len[7:0], 1'b1);
        if (len == 0 || len > max_len_cfg)
            return;
        for (int i = 0; i < len; i++)
        begin
            b   = ramp ? i[7:0] : 8'($urandom);
            sum = sum ^ b;
            push_byte(b, 1'b1);
        end
        push_byte(good ? sum : (sum ^ 8'($urandom_range(1, 255))), 1'b1);
    endtask

    // Mostly well-formed frames with random content, short ones far more
    // often than long; the rest is line noise, clear-to-send, over-long
    // lengths and frames cut short.
    task automatic random_traffic(input int n);
        int pick;
        int lim;
        int len;
        phase_beats = 0;
        while (phase_beats < n)
        begin
            pick = $urandom_range(0, 99);
            lim  = (max_len_cfg < 16) ? int'(max_len_cfg) : 16;
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom_range(0, 254)), 1'b0);
            end
            else if (pick < 14)
                push_frame(0, 1'b1, 1'b0);
            else if (pick < 22)
            begin
                if (max_len_cfg < 8'd255)
                    push_frame($urandom_range(int'(max_len_cfg) + 1, 255), 1'b1, 1'b0);
            end
            else if (pick < 28)
            begin
                // cut short: whatever follows is read as the rest of it
                len = (lim == 0) ? 1 : $urandom_range(1, lim);
                push_byte(START_BYTE, 1'b1);
                push_byte(len[7:0], 1'b1);
                repeat ($urandom_range(0, len - 1))
                    push_byte(8'($urandom), 1'b1);
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    len = (max_len_cfg == 8'd0) ? $urandom_range(1, 255)
                                                : $urandom_range(1, max_len_cfg);
                else
                    len = (lim == 0) ? $urandom_range(1, 255) : $urandom_range(1, lim);
                push_frame(len, $urandom_range(0, 99) < 85, 1'b0);
            end
        end
    endtask

    // Waits until every byte is taken and every result has come back.
    task automatic settle();
        while (bytes_taken != bytes_pushed || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_max_length(input logic [7:0] v);
        @(posedge clk);
        max_length_we    <= 1'b1;
        max_length_wdata <= v;
        @(posedge clk);
        max_length_we <= 1'b0;
        max_len_cfg = v;
    endtask

    // Sender: one beat held until taken, bursts of random length with random
    // gaps, now and then a long burst with no gap at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_frame_byte(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || byte_q.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_q.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall rate picked afresh for each span of cycles. Once, with
    // plenty still to send, it holds off for HOLD_CYCLES so that the block
    // fills and pushes back on its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 150 && byte_q.size() > 64)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_span = $urandom_range(16, 128);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            else
                stall_span--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor: every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: kind %0d data %h index %0d ok %0d",
                         $time, kind, data, byte_index, check_ok);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
                    errors++;
                end
                if (data !== want.data)
                begin
                    $display("%0t: data expected %h got %h", $time, want.data, data);
                    errors++;
                end
                if (byte_index !== want.byte_index)
                begin
                    $display("%0t: byte_index expected %0d got %0d",
                             $time, want.byte_index, byte_index);
                    errors++;
                end
                if (check_ok !== want.check_ok)
                begin
                    $display("%0t: check_ok expected %0d got %0d",
                             $time, want.check_ok, check_ok);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of max_length (100).
        // Line noise while hunting, extremes below the start byte.
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFE, 1'b0);
        // A second 0xFF is a length of 255, too long here.
        push_frame(255, 1'b1, 1'b0);
        push_frame(0, 1'b1, 1'b0);
        push_frame(101, 1'b1, 1'b0);
        // One-byte frame, good check (FF ^ 01 ^ AA).
        push_byte(START_BYTE, 1'b1);
        push_byte(8'h01, 1'b1);
        push_byte(8'hAA, 1'b1);
        push_byte(8'h54, 1'b1);
        // Payload extremes, once with a good check, once with a bad one.
        push_byte(START_BYTE, 1'b1);
        push_byte(8'h02, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h02, 1'b1);
        push_byte(START_BYTE, 1'b1);
        push_byte(8'h02, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h03, 1'b1);
        // Longest frame the reset setting takes.
        push_frame(100, 1'b1, 1'b0);
        random_traffic(200);
        settle();

        // Widest setting: a full 255-byte frame, indices 0 to 254.
        write_max_length(8'd255);
        push_frame(255, 1'b1, 1'b1);
        random_traffic(250);
        settle();

        // Zero: every nonzero length is too long.
        write_max_length(8'd0);
        push_frame(1, 1'b1, 1'b0);
        push_frame(0, 1'b1, 1'b0);
        push_frame(255, 1'b1, 1'b0);
        random_traffic(50);
        settle();

        // Narrowest useful setting.
        write_max_length(8'd1);
        push_frame(1, 1'b1, 1'b0);
        push_frame(2, 1'b1, 1'b0);
        random_traffic(150);
        settle();

        repeat (3)
        begin
            write_max_length(8'($urandom_range(1, 255)));
            random_traffic(120);
            settle();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/ufdx_pkg.sv
rtl/ufdx_parser.sv
rtl/ufdx_skid.sv
rtl/uart_frame_deframer_xor_top.sv
sim/testbench.sv
